FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true at a rising clock edge.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/core/olt_pkg.sv
// Types and codes shared by the ordered id list table.
`default_nettype none
package olt_pkg;

   localparam int VALUE_BITS = 16;

   // item kinds
   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_LIST   = 2'd2;
   localparam logic [1:0] KIND_DRAIN  = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]            kind;
      logic [VALUE_BITS-1:0] proc_id;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [VALUE_BITS-1:0] value;
      logic                  is_count;
      logic                  last;
   } rsp_type;

   // per-cell controls
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage
`default_nettype wire

FILE: rtl/core/olt_cell.sv
// One list cell: holds an id, loads a new one or takes its right neighbor's.
`default_nettype none
module olt_cell #(
   parameter int ID_BITS = 16
) (
   input  logic                 clock,
   input  olt_pkg::cell_ctl_type ctl,
   input  logic [ID_BITS-1:0]   next_id,
   input  logic [ID_BITS-1:0]   load_id,
   output logic [ID_BITS-1:0]   id
);
   import olt_pkg::*;

   logic [ID_BITS-1:0] id_ff;
   logic [ID_BITS-1:0] id_in;

   // load wins over shift: the rotating head re-enters at the tail cell
   always_comb begin
      id_in = id_ff;
      if (ctl.load) begin
         id_in = load_id;
      end else if (ctl.shift) begin
         id_in = next_id;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id = id_ff;

endmodule
`default_nettype wire

FILE: rtl/core/ordered_id_list_table_core.sv
// Add: result via the reply state. Remove: one rotation step per entry, then a
// status result. List/drain: one result per cycle while the output is not
// stalled (count ids, drain adds a leading count result), set by the single
// head cell read as the cell chain rotates. New item taken once the last result
// is in the output register. Reset clears count and control; cells keep data.
`default_nettype none
module ordered_id_list_table_core #(
   parameter int LIST_DEPTH = 16,
   parameter int ID_BITS    = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  olt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output olt_pkg::rsp_type rsp_data
);
   import olt_pkg::*;

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_REPLY = 5'b00010,
      S_SCAN  = 5'b00100,
      S_COUNT = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   steps_ff, steps_in;
   logic               found_ff, found_in;
   logic [1:0]         op_kind_ff, op_kind_in;
   logic [ID_BITS-1:0] op_id_ff, op_id_in;
   logic [1:0]         op_status_ff, op_status_in;
   logic               op_is_count_ff, op_is_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [ID_BITS-1:0] cell_id [LIST_DEPTH];
   cell_ctl_type       cell_ctl [LIST_DEPTH];
   logic [ID_BITS-1:0] load_id;
   logic [CNT_W-1:0]   load_idx;
   logic               load_en;
   logic               shift_en;
   logic               rsp_load;
   rsp_type            rsp_next;
   logic               out_free;
   logic               match;
   logic [ID_BITS-1:0] head;
   logic [ID_BITS-1:0] id_in;
   logic [31:0]        head_wide;

   // cell chain, each cell but the last takes its right neighbor on a shift; the last keeps its own
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic [ID_BITS-1:0] nb_id;
      if (i == LIST_DEPTH - 1) begin : g_end
         assign nb_id = cell_id[i];
      end else begin : g_mid
         assign nb_id = cell_id[i+1];
      end
      assign cell_ctl[i].shift = shift_en;
      assign cell_ctl[i].load  = load_en && (load_idx == CNT_W'(i));
      olt_cell #(
         .ID_BITS (ID_BITS)
      ) u_cell (
         .clock   (clock),
         .ctl     (cell_ctl[i]),
         .next_id (nb_id),
         .load_id (load_id),
         .id      (cell_id[i])
      );
   end

   assign head      = cell_id[0];
   assign head_wide = 32'(head);
   assign id_in     = ID_BITS'(req_data.proc_id);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign match     = !found_ff && (head == op_id_ff);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      steps_in       = steps_ff;
      found_in       = found_ff;
      op_kind_in     = op_kind_ff;
      op_id_in       = op_id_ff;
      op_status_in   = op_status_ff;
      op_is_count_in = op_is_count_ff;
      load_en        = 1'b0;
      load_idx       = count_ff - CNT_W'(1);
      load_id        = head;
      shift_en       = 1'b0;
      rsp_load       = 1'b0;
      rsp_next       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_kind_in     = req_data.kind;
               op_id_in       = id_in;
               steps_in       = count_ff;
               found_in       = 1'b0;
               op_status_in   = ST_OK;
               op_is_count_in = 1'b0;
               case (req_data.kind) inside
                  KIND_ADD: begin
                     if (count_ff == CNT_W'(LIST_DEPTH)) begin
                        op_status_in = ST_FULL;
                     end else begin
                        load_en  = 1'b1;
                        load_idx = count_ff;
                        load_id  = id_in;
                        count_in = count_ff + CNT_W'(1);
                     end
                     state_in = S_REPLY;
                  end
                  KIND_REMOVE: begin
                     if (count_ff == '0) begin
                        op_status_in = ST_EMPTY;
                        state_in     = S_REPLY;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  KIND_LIST, KIND_DRAIN: begin
                     if (count_ff == '0) begin
                        op_status_in   = ST_EMPTY;
                        op_is_count_in = (req_data.kind == KIND_DRAIN);
                        state_in       = S_REPLY;
                     end else if (req_data.kind == KIND_DRAIN) begin
                        state_in = S_COUNT;
                     end else begin
                        state_in = S_EMIT;
                     end
                  end
               endcase
            end
         end
         S_REPLY: begin
            if (out_free) begin
               rsp_load          = 1'b1;
               rsp_next.status   = op_status_ff;
               rsp_next.is_count = op_is_count_ff;
               rsp_next.last     = 1'b1;
               state_in          = S_IDLE;
            end
         end
         S_SCAN: begin
            // head either drops out (first match) or re-enters at the tail
            shift_en = 1'b1;
            steps_in = steps_ff - CNT_W'(1);
            if (match) begin
               found_in = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end else begin
               load_en = 1'b1;
            end
            if (steps_ff == CNT_W'(1)) begin
               op_status_in = (found_ff || match) ? ST_OK : ST_NOT_FOUND;
               state_in     = S_REPLY;
            end
         end
         S_COUNT: begin
            if (out_free) begin
               rsp_load          = 1'b1;
               rsp_next.status   = ST_OK;
               rsp_next.value    = VALUE_BITS'(count_ff);
               rsp_next.is_count = 1'b1;
               state_in          = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_load        = 1'b1;
               rsp_next.status = ST_OK;
               rsp_next.value  = head_wide[VALUE_BITS-1:0];
               rsp_next.last   = (steps_ff == CNT_W'(1));
               shift_en        = 1'b1;
               load_en         = 1'b1;
               steps_in        = steps_ff - CNT_W'(1);
               if (steps_ff == CNT_W'(1)) begin
                  if (op_kind_ff == KIND_DRAIN) begin
                     count_in = '0;
                  end
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = rsp_load ? rsp_next : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff       <= steps_in;
      found_ff       <= found_in;
      op_kind_ff     <= op_kind_in;
      op_id_ff       <= op_id_in;
      op_status_ff   <= op_status_in;
      op_is_count_ff <= op_is_count_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/olt_checker.sv
// Port-level checks for the ordered id list table, bound to the core module.
`default_nettype none
`include "assert_macros.svh"
module olt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input olt_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input olt_pkg::rsp_type rsp_data
);
   import olt_pkg::*;

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result changed while stalled")
   `ASSERT_CLK(a_busy_after_req, clock, reset, req_valid && req_ready |=> !req_ready, "second transfer taken while an item is in work")
   `ASSERT_NEVER(a_count_not_last, clock, reset, rsp_valid && rsp_data.is_count && rsp_data.status == ST_OK && rsp_data.last, "drain count result flagged last")
   `ASSERT_CLK(a_error_single, clock, reset, rsp_valid && rsp_data.status != ST_OK |-> rsp_data.last && rsp_data.value == '0, "error status result not a single zero result")

endmodule

bind ordered_id_list_table_core olt_checker u_olt_checker (.*);
`default_nettype wire
